// File: src/addressable_led_serializer_top_defines.svh
// Assertion macros used by the serializer back end.
`ifndef ADDRESSABLE_LED_SERIALIZER_TOP_DEFINES_SVH
`define ADDRESSABLE_LED_SERIALIZER_TOP_DEFINES_SVH

`ifndef SYNTH
`define ALS_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("als assertion failed");
`define ALS_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("als forbidden condition seen");
`else
`define ALS_ASSERT(label, clk, rst_n, prop)
`define ALS_ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

// File: src/als_pkg.sv
// Types, constants and codes shared by the LED serializer modules.
package als_pkg;

  localparam int unsigned PIXEL_COUNT = 64;
  localparam int unsigned FRAME_BYTES = 3 * PIXEL_COUNT;
  localparam int unsigned PIX_W       = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
  localparam int unsigned BYTE_W      = $clog2(FRAME_BYTES);

  localparam int unsigned CMD_DEPTH = 4;
  localparam int unsigned CMD_PTR_W = $clog2(CMD_DEPTH);
  localparam int unsigned CMD_CNT_W = $clog2(CMD_DEPTH + 1);

  localparam logic [7:0] BRIGHTNESS_RST = 8'd255;
  localparam logic [7:0] ONE_HIGH_RST   = 8'd128;
  localparam logic [7:0] ZERO_HIGH_RST  = 8'd32;
  localparam logic [7:0] PERIOD_RST     = 8'd144;

  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_CLEAR = 2'd1,
    MODE_SHOW  = 2'd2,
    MODE_TICK  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    CFG_BRIGHTNESS = 2'd0,
    CFG_ONE_HIGH   = 2'd1,
    CFG_ZERO_HIGH  = 2'd2,
    CFG_PERIOD     = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    mode_e             mode;
    logic              in_range;
    logic [PIX_W-1:0]  addr;
    logic [23:0]       pixel;
  } cmd_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic refused;
    logic frame_done;
  } res_t;

endpackage

// File: src/als_front.sv
// Front end: classifies incoming items and queues them for the back end.
module als_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push,
  output logic            full,
  input  logic [1:0]      mode_i,
  input  logic [7:0]      pixel_index_i,
  input  logic [7:0]      first_byte_i,
  input  logic [7:0]      second_byte_i,
  input  logic [7:0]      third_byte_i,
  output als_pkg::cmd_t   cmd_o,
  output logic            cmd_valid_o,
  input  logic            cmd_take_i
);

  als_pkg::cmd_t                     slot_q [als_pkg::CMD_DEPTH];
  logic [als_pkg::CMD_PTR_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic [als_pkg::CMD_PTR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [als_pkg::CMD_CNT_W-1:0]     cnt_q, cnt_d;
  als_pkg::cmd_t                     cmd_d;
  logic                              acc;
  logic                              take;

  always_comb begin
    cmd_d.mode     = als_pkg::mode_e'(mode_i);
    cmd_d.in_range = {1'b0, pixel_index_i} < 9'(als_pkg::PIXEL_COUNT);
    cmd_d.addr     = pixel_index_i[als_pkg::PIX_W-1:0];
    cmd_d.pixel    = {first_byte_i, second_byte_i, third_byte_i};
  end

  assign full        = (cnt_q == als_pkg::CMD_CNT_W'(als_pkg::CMD_DEPTH));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = slot_q[rd_ptr_q];
  assign acc         = push && !full;
  assign take        = cmd_take_i && cmd_valid_o;

  always_comb begin
    wr_ptr_d = acc  ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = take ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (acc && !take) begin
      cnt_d = cnt_q + 1'b1;
    end else if (take && !acc) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      slot_q[wr_ptr_q] <= cmd_d;
    end
  end

endmodule

// File: src/als_back.sv
// Back end: pixel store, byte prefetch and scaling, bit timing and result queue.
`include "addressable_led_serializer_top_defines.svh"

module als_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [1:0]     cfg_index_i,
  input  logic [7:0]     cfg_data_i,
  input  als_pkg::cmd_t  cmd_i,
  input  logic           cmd_valid_i,
  output logic           cmd_take_o,
  output logic           empty,
  input  logic           pop,
  output als_pkg::res_t  res_o
);

  // Configuration registers.
  logic [7:0] brightness_q, one_high_q, zero_high_q, period_q;

  // Pixel store with one valid bit per entry; an invalid entry reads as zero.
  logic [23:0]                       mem_q [als_pkg::PIXEL_COUNT];
  logic [als_pkg::PIXEL_COUNT-1:0]   valid_q;
  logic [23:0]                       rd_data_q;
  logic                              rd_valid_q;

  // Frame state.
  logic                              sending_q;
  logic [7:0]                        shown_q;
  logic [als_pkg::BYTE_W-1:0]        byte_pos_q;
  logic [2:0]                        bit_pos_q;
  logic [7:0]                        tick_q;
  logic [7:0]                        cur_q;
  logic                              cur_valid_q;
  logic [7:0]                        nb_q;
  logic                              nb_valid_q;

  // Prefetch pointer and the read in flight.
  logic [als_pkg::PIX_W-1:0]         fpix_q;
  logic [1:0]                        fsel_q;
  logic                              fdone_q;
  logic                              s1_q;
  logic [1:0]                        s1_sel_q;

  // Result queue, two entries.
  als_pkg::res_t                     out_q [2];
  logic                              out_wr_q, out_rd_q;
  logic [1:0]                        out_cnt_q;

  logic          issue;
  logic [7:0]    raw_byte;
  logic [15:0]   prod;
  logic          is_tick;
  logic          end_bit;
  logic          byte_end;
  logic          last_byte;
  logic [7:0]    high_ticks;
  logic          stall;
  logic          take;
  logic          pop_acc;
  logic          wr_en;
  als_pkg::res_t res_d;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brightness_q <= als_pkg::BRIGHTNESS_RST;
      one_high_q   <= als_pkg::ONE_HIGH_RST;
      zero_high_q  <= als_pkg::ZERO_HIGH_RST;
      period_q     <= als_pkg::PERIOD_RST;
    end else if (cfg_valid_i) begin
      unique case (als_pkg::cfg_idx_e'(cfg_index_i))
        als_pkg::CFG_BRIGHTNESS: brightness_q <= cfg_data_i;
        als_pkg::CFG_ONE_HIGH:   one_high_q   <= cfg_data_i;
        als_pkg::CFG_ZERO_HIGH:  zero_high_q  <= cfg_data_i;
        als_pkg::CFG_PERIOD:     period_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The next byte is fetched while the current one is on the line.
  assign issue = sending_q && !fdone_q && !nb_valid_q && !s1_q;

  always_comb begin
    case (s1_sel_q)
      2'd0:    raw_byte = rd_data_q[23:16];
      2'd1:    raw_byte = rd_data_q[15:8];
      2'd2:    raw_byte = rd_data_q[7:0];
      default: raw_byte = 8'd0;
    endcase
    if (!rd_valid_q) begin
      raw_byte = 8'd0;
    end
  end

  assign prod = 16'(raw_byte) * 16'(shown_q);

  assign is_tick    = (cmd_i.mode == als_pkg::MODE_TICK);
  assign high_ticks = cur_q[7] ? one_high_q : zero_high_q;
  assign end_bit    = ({1'b0, tick_q} + 9'd1) >= {1'b0, period_q};
  assign byte_end   = end_bit && (bit_pos_q == 3'd7);
  assign last_byte  = (byte_pos_q == als_pkg::BYTE_W'(als_pkg::FRAME_BYTES - 1));

  // A tick waits until the byte it needs has been scaled.
  assign stall = is_tick && sending_q &&
                 (!cur_valid_q || (byte_end && !last_byte && !nb_valid_q));
  assign take       = cmd_valid_i && (out_cnt_q != 2'd2) && !stall;
  assign cmd_take_o = take;
  assign pop_acc    = pop && (out_cnt_q != 2'd0);
  assign wr_en      = take && !sending_q && (cmd_i.mode == als_pkg::MODE_WRITE) &&
                      cmd_i.in_range;

  always_comb begin
    res_d = '0;
    if (!is_tick) begin
      if (sending_q) begin
        res_d.refused  = 1'b1;
        res_d.busy_res = 1'b1;
      end else if (cmd_i.mode == als_pkg::MODE_SHOW) begin
        res_d.busy_res = 1'b1;
      end
    end else if (sending_q) begin
      res_d.busy_res   = 1'b1;
      res_d.line_level = tick_q < high_ticks;
      res_d.frame_done = byte_end && last_byte;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[cmd_i.addr] <= cmd_i.pixel;
    end
    if (issue) begin
      rd_data_q <= mem_q[fpix_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      rd_valid_q  <= 1'b0;
      sending_q   <= 1'b0;
      shown_q     <= als_pkg::BRIGHTNESS_RST;
      byte_pos_q  <= '0;
      bit_pos_q   <= '0;
      tick_q      <= '0;
      cur_q       <= '0;
      cur_valid_q <= 1'b0;
      nb_q        <= '0;
      nb_valid_q  <= 1'b0;
      fpix_q      <= '0;
      fsel_q      <= '0;
      fdone_q     <= 1'b0;
      s1_q        <= 1'b0;
      s1_sel_q    <= '0;
    end else begin
      if (s1_q) begin
        nb_q       <= prod[15:8];
        nb_valid_q <= 1'b1;
      end
      s1_q <= issue;
      if (issue) begin
        rd_valid_q <= valid_q[fpix_q];
        s1_sel_q   <= fsel_q;
        if (fsel_q == 2'd2) begin
          fsel_q <= '0;
          if (fpix_q == als_pkg::PIX_W'(als_pkg::PIXEL_COUNT - 1)) begin
            fdone_q <= 1'b1;
          end else begin
            fpix_q <= fpix_q + 1'b1;
          end
        end else begin
          fsel_q <= fsel_q + 2'd1;
        end
      end
      if (sending_q && !cur_valid_q && nb_valid_q) begin
        cur_q       <= nb_q;
        cur_valid_q <= 1'b1;
        nb_valid_q  <= 1'b0;
      end
      if (wr_en) begin
        valid_q[cmd_i.addr] <= 1'b1;
      end
      if (take && !sending_q) begin
        case (cmd_i.mode)
          als_pkg::MODE_CLEAR: valid_q <= '0;
          als_pkg::MODE_SHOW: begin
            sending_q   <= 1'b1;
            shown_q     <= brightness_q;
            byte_pos_q  <= '0;
            bit_pos_q   <= '0;
            tick_q      <= '0;
            cur_valid_q <= 1'b0;
            nb_valid_q  <= 1'b0;
            fpix_q      <= '0;
            fsel_q      <= '0;
            fdone_q     <= 1'b0;
            s1_q        <= 1'b0;
          end
          default: ;
        endcase
      end else if (take && is_tick) begin
        if (end_bit) begin
          tick_q <= '0;
          if (bit_pos_q == 3'd7) begin
            bit_pos_q <= '0;
            if (last_byte) begin
              sending_q   <= 1'b0;
              byte_pos_q  <= '0;
              cur_valid_q <= 1'b0;
            end else begin
              byte_pos_q <= byte_pos_q + 1'b1;
              cur_q      <= nb_q;
              nb_valid_q <= 1'b0;
            end
          end else begin
            bit_pos_q <= bit_pos_q + 3'd1;
            cur_q     <= {cur_q[6:0], 1'b0};
          end
        end else begin
          tick_q <= tick_q + 8'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_wr_q  <= 1'b0;
      out_rd_q  <= 1'b0;
      out_cnt_q <= '0;
    end else begin
      if (take) begin
        out_wr_q <= !out_wr_q;
      end
      if (pop_acc) begin
        out_rd_q <= !out_rd_q;
      end
      if (take && !pop_acc) begin
        out_cnt_q <= out_cnt_q + 2'd1;
      end else if (pop_acc && !take) begin
        out_cnt_q <= out_cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q[out_wr_q] <= res_d;
    end
  end

  assign empty = (out_cnt_q == 2'd0);
  assign res_o = out_q[out_rd_q];

  `ALS_ASSERT_NEVER(a_out_overflow, clk_i, rst_ni, out_cnt_q == 2'd3)
  `ALS_ASSERT_NEVER(a_fetch_overrun, clk_i, rst_ni, s1_q && nb_valid_q)
  `ALS_ASSERT(a_idle_no_fetch, clk_i, rst_ni, !sending_q |-> !s1_q)
  `ALS_ASSERT(a_done_ends_frame, clk_i, rst_ni, (take && res_d.frame_done) |=> !sending_q)

endmodule

// File: src/addressable_led_serializer_top.sv
// Top level of the addressable LED serializer: front end, back end and ports.
//
//   Channel   Handshake                      Payload
//   input     push / full                    mode, pixel_index, first/second/third_byte
//   result    empty / pop                    line_level, busy_res, refused, frame_done
//   config    cfg_valid / cfg_ready          cfg_index, cfg_data
//
// One item is accepted per cycle and one result leaves per cycle in steady state, while
// neither queue is full and no tick waits. An accepted item passes through the four-entry
// command queue and then the two-entry result queue before its result can be popped.
// A tick straight after a show waits while byte zero is read from the pixel store
// and scaled; later bytes are prefetched during the frame.
// The store is cleared at reset by per-entry valid bits, so there is no clearing pass.
// Either side may stall on its own; full rises when the four-entry queue is taken.
module addressable_led_serializer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  mode_i,
  input  logic [7:0]  pixel_index_i,
  input  logic [7:0]  first_byte_i,
  input  logic [7:0]  second_byte_i,
  input  logic [7:0]  third_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic        line_level_o,
  output logic        busy_res_o,
  output logic        refused_o,
  output logic        frame_done_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  als_pkg::cmd_t cmd;
  logic          cmd_valid;
  logic          cmd_take;
  als_pkg::res_t res;

  als_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .mode_i        (mode_i),
    .pixel_index_i (pixel_index_i),
    .first_byte_i  (first_byte_i),
    .second_byte_i (second_byte_i),
    .third_byte_i  (third_byte_i),
    .cmd_o         (cmd),
    .cmd_valid_o   (cmd_valid),
    .cmd_take_i    (cmd_take)
  );

  als_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .cmd_take_o  (cmd_take),
    .empty       (empty),
    .pop         (pop),
    .res_o       (res)
  );

  assign line_level_o = res.line_level;
  assign busy_res_o   = res.busy_res;
  assign refused_o    = res.refused;
  assign frame_done_o = res.frame_done;

endmodule
